[hw/rtl/gda_pkg.sv]
package gda_pkg;

	// Month codes for January, February and December, and the first and last day codes.
	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;
	localparam logic [4:0] DAY_FIRST = 5'd1;
	localparam logic [4:0] DAY_LAST_DEC = 5'd31;

	// Length of the Gregorian cycle used for the leap-year rule.
	localparam int unsigned LEAP_CYCLE = 400;
	localparam int unsigned R400_W = 9;

	localparam logic [R400_W-1:0] R400_MAX = R400_W'(LEAP_CYCLE - 1);
	localparam logic [R400_W-1:0] R400_C100 = R400_W'(100);
	localparam logic [R400_W-1:0] R400_C200 = R400_W'(200);
	localparam logic [R400_W-1:0] R400_C300 = R400_W'(300);

	// The year over 400 is taken as (year / 16) / 25, the last step by a multiply
	// with ceil(2^17 / 25) and a shift by 17, exact for every dividend below 43690.
	localparam int unsigned CENTURY_SHIFT = 4;
	localparam int unsigned RECIP_W = 13;
	localparam logic [RECIP_W-1:0] RECIP_25 = 13'd5243;
	localparam int unsigned RECIP_SHIFT = 17;

	localparam logic [8:0] YEAR_DAYS = 9'd365;
	localparam logic [8:0] LEAP_YEAR_DAYS = 9'd366;
	localparam logic [4:0] FEB_LEAP_DAYS = 5'd29;

	localparam logic [4:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// Days in the months before the given one, in a common year.
	localparam logic [8:0] CUM_DAYS [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_CLAMP,
		S_SUM,
		S_YEAR,
		S_MONTH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mod_step;
		logic clamp;
		logic sum;
		logic year_step;
		logic month_step;
	} cmd_t;

	typedef struct packed {
		logic year_fits;
		logic year_last;
		logic month_fits;
	} stat_t;

	// Leap test from the year modulo 400.
	function automatic logic is_leap(input logic [R400_W-1:0] r);
		logic by4;
		logic century;
		begin
			by4 = (r[1:0] == 2'd0);
			century = (r == R400_C100) || (r == R400_C200) || (r == R400_C300);
			return by4 && !century;
		end
	endfunction

	// Length of month m (1..12).
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [3:0] idx;
		begin
			idx = m - 4'd1;
			if (m == MONTH_FEB && leap)
				return FEB_LEAP_DAYS;
			return MONTH_LEN[idx];
		end
	endfunction

	// Days in the months before month m (1..12) of the year.
	function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
		logic [3:0] idx;
		begin
			idx = m - 4'd1;
			if (leap && m > MONTH_FEB)
				return CUM_DAYS[idx] + 9'd1;
			return CUM_DAYS[idx];
		end
	endfunction

endpackage

[hw/rtl/gregorian_date_add_days_top.sv]
// From the accepting edge a request passes S_MOD, S_CLAMP and S_SUM, loops in S_YEAR
// while whole years remain and in S_MONTH while whole months remain in the last year,
// and ends in S_DONE (S_MONTH is skipped when the year saturates).
// Throughput: one request at a time; a new request is taken the cycle after done.
// The year-skipping loop, one year per cycle, dominates the time for large day counts.
// Reset (arst_n low, asynchronous) returns the controller to idle; results are one-cycle
// strobes on done and the receiver cannot stall them.
module gregorian_date_add_days_top
	import gda_pkg::*;
#(
	parameter int YEAR_WIDTH = 12,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [YEAR_WIDTH-1:0]  start_year,
	input  logic [3:0]             start_month,
	input  logic [4:0]             start_day,
	input  logic [COUNT_WIDTH-1:0] days_to_add,
	output logic                   done,
	output logic [YEAR_WIDTH-1:0]  result_year,
	output logic [3:0]             result_month,
	output logic [4:0]             result_day,
	output logic                   year_overflow
);

	// The controller walks a request through its phases: the year modulo 400 is
	// found in S_MOD by a reciprocal multiply, so that the leap rule can then
	// follow the year by a wrapping counter. The start day is clamped to its
	// month, the day of year is summed with the count, whole years are removed one
	// per cycle, then whole months, and the remainder is the day of the month.
	cmd_t  cmd;
	stat_t stat;

	gda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// The datapath holds the request and produces the result in place; its
	// registers are read by the outputs during the done cycle. Nothing in it
	// needs a reset, since every register is written during a request before it is used.
	gda_dp #(
		.YEAR_WIDTH  (YEAR_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.stat          (stat),
		.start_year    (start_year),
		.start_month   (start_month),
		.start_day     (start_day),
		.days_to_add   (days_to_add),
		.result_year   (result_year),
		.result_month  (result_month),
		.result_day    (result_day),
		.year_overflow (year_overflow)
	);

	// A result strobe ends the request: the block is idle in the next cycle.
	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("done not followed by idle");

	// An accepted request makes the block busy from the edge that takes it.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted without going busy");

	// A delivered month is always a real month.
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result_month >= MONTH_JAN) && (result_month <= MONTH_DEC))
		else $error("result month out of range");

	// Saturation gives the last representable day.
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && year_overflow |-> (result_year == '1) && (result_month == MONTH_DEC)
			&& (result_day == DAY_LAST_DEC))
		else $error("overflow result not saturated");

endmodule

[hw/rtl/gda_ctrl.sv]
module gda_ctrl
	import gda_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy,
	output logic  done
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start)
					state_d = S_MOD;
			end
			S_MOD: state_d = S_CLAMP;
			S_CLAMP: state_d = S_SUM;
			S_SUM: state_d = S_YEAR;
			S_YEAR: begin
				if (stat.year_fits)
					state_d = S_MONTH;
				else if (stat.year_last)
					state_d = S_DONE;
			end
			S_MONTH: begin
				if (stat.month_fits)
					state_d = S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
			end
			S_MOD: cmd.mod_step = 1'b1;
			S_CLAMP: cmd.clamp = 1'b1;
			S_SUM: cmd.sum = 1'b1;
			S_YEAR: cmd.year_step = 1'b1;
			S_MONTH: cmd.month_step = 1'b1;
			S_DONE: done = 1'b1;
			default: busy = 1'b1;
		endcase
	end

endmodule

[hw/rtl/gda_dp.sv]
module gda_dp
	import gda_pkg::*;
#(
	parameter int YEAR_WIDTH = 12,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	input  logic [YEAR_WIDTH-1:0]  start_year,
	input  logic [3:0]             start_month,
	input  logic [4:0]             start_day,
	input  logic [COUNT_WIDTH-1:0] days_to_add,
	output logic [YEAR_WIDTH-1:0]  result_year,
	output logic [3:0]             result_month,
	output logic [4:0]             result_day,
	output logic                   year_overflow
);

	localparam int QW = YEAR_WIDTH - int'(CENTURY_SHIFT);
	localparam int PW = QW + int'(RECIP_W);
	localparam int REM_W = COUNT_WIDTH + 2;
	localparam logic [YEAR_WIDTH-1:0] CYCLE_YEARS = YEAR_WIDTH'(LEAP_CYCLE);

	logic [YEAR_WIDTH-1:0]  y_q;
	logic [3:0]             m_q;
	logic [4:0]             d_q;
	logic [COUNT_WIDTH-1:0] add_q;
	logic [R400_W-1:0]      r400_q;
	logic [REM_W-1:0]       rem_q;
	logic                   ovf_q;

	logic                   leap;
	logic [4:0]             mlen;
	logic [8:0]             ylen;
	logic [QW-1:0]          y16;
	logic [PW-1:0]          prod;
	logic [YEAR_WIDTH-1:0]  n400;
	logic [YEAR_WIDTH-1:0]  y_mod;

	assign leap = is_leap(r400_q);
	assign mlen = month_days(m_q, leap);
	assign ylen = leap ? LEAP_YEAR_DAYS : YEAR_DAYS;

	// Year modulo 400 in one cycle: the count of whole 400-year cycles comes from
	// a reciprocal multiply of the year over 16, and is taken back off the year.
	assign y16 = y_q[YEAR_WIDTH-1:CENTURY_SHIFT];
	assign prod = PW'(y16) * PW'(RECIP_25);
	assign n400 = YEAR_WIDTH'(prod >> RECIP_SHIFT);
	assign y_mod = y_q - n400 * CYCLE_YEARS;

	assign stat.year_fits = (rem_q <= REM_W'(ylen));
	assign stat.year_last = (y_q == '1);
	assign stat.month_fits = (m_q == MONTH_DEC) || (rem_q <= REM_W'(mlen));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			y_q <= (start_year == '0) ? YEAR_WIDTH'(1) : start_year;
			if (start_month == 4'd0)
				m_q <= MONTH_JAN;
			else if (start_month > MONTH_DEC)
				m_q <= MONTH_DEC;
			else
				m_q <= start_month;
			d_q <= (start_day == 5'd0) ? DAY_FIRST : start_day;
			add_q <= days_to_add;
			ovf_q <= 1'b0;
		end
		if (cmd.mod_step) begin
			r400_q <= R400_W'(y_mod);
		end
		if (cmd.clamp) begin
			if (d_q > mlen)
				d_q <= mlen;
		end
		if (cmd.sum) begin
			rem_q <= REM_W'(d_q) + REM_W'(days_before(m_q, leap)) + REM_W'(add_q);
		end
		if (cmd.year_step) begin
			if (stat.year_fits) begin
				m_q <= MONTH_JAN;
			end else begin
				if (stat.year_last) begin
					ovf_q <= 1'b1;
					m_q <= MONTH_DEC;
					rem_q <= REM_W'(DAY_LAST_DEC);
				end else begin
					rem_q <= rem_q - REM_W'(ylen);
					y_q <= y_q + YEAR_WIDTH'(1);
					r400_q <= (r400_q == R400_MAX) ? '0 : r400_q + R400_W'(1);
				end
			end
		end
		if (cmd.month_step && !stat.month_fits) begin
			rem_q <= rem_q - REM_W'(mlen);
			m_q <= m_q + 4'd1;
		end
	end

	assign result_year = y_q;
	assign result_month = m_q;
	assign result_day = rem_q[4:0];
	assign year_overflow = ovf_q;

endmodule

[bench/gregorian_date_add_days_top_tb.sv]
module gregorian_date_add_days_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gda_pkg::*;

	// Widths match the default build of the block.
	localparam int YW = 12;
	localparam int CW = 16;
	localparam int unsigned LAST_YEAR = (1 << YW) - 1;

	// The run is far shorter than this; hitting it means the handshake hung.
	localparam int unsigned LIMIT_CYCLES = 1000000;
	// Worst request: the setup states, then up to ~180 years and 11 months skipped.
	localparam int unsigned DRAIN_CYCLES = 256;
	localparam int unsigned RANDOM_REQUESTS = 450;
	localparam int unsigned DIRECTED_REQUESTS = 24;

	typedef struct packed {
		logic [YW-1:0] year;
		logic [3:0]    month;
		logic [4:0]    day;
		logic          ovf;
	} date_t;

	// One row of the directed table. When typed is set, want holds the date that
	// is obvious by hand; otherwise the predictor supplies it.
	typedef struct packed {
		logic [YW-1:0] year;
		logic [3:0]    month;
		logic [4:0]    day;
		logic [CW-1:0] count;
		logic          typed;
		date_t         want;
	} stim_row_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic [YW-1:0] start_year;
	logic [3:0]    start_month;
	logic [4:0]    start_day;
	logic [CW-1:0] days_to_add;
	logic          done;
	logic [YW-1:0] result_year;
	logic [3:0]    result_month;
	logic [4:0]    result_day;
	logic          year_overflow;

	// Dates still owed by the block, oldest first.
	date_t       pending_dates [$];
	int unsigned mismatch_count;
	int unsigned cycle_count;

	// Directed requests: every clamp on the incoming date, leap-day and year-end
	// crossings, the century rules, and the saturation at the last year.
	stim_row_t directed_rows [DIRECTED_REQUESTS] = '{
		// All-zero date: year, month and day each pulled up to one.
		'{12'd0,    4'd0,  5'd0,  16'd0,     1'b1, '{12'd1,    4'd1,  5'd1,  1'b0}},
		'{12'd2000, 4'd0,  5'd15, 16'd0,     1'b1, '{12'd2000, 4'd1,  5'd15, 1'b0}},
		// Months above twelve are pulled down to December.
		'{12'd2001, 4'd13, 5'd31, 16'd0,     1'b1, '{12'd2001, 4'd12, 5'd31, 1'b0}},
		'{12'd2001, 4'd15, 5'd1,  16'd0,     1'b1, '{12'd2001, 4'd12, 5'd1,  1'b0}},
		'{12'd2023, 4'd6,  5'd0,  16'd0,     1'b1, '{12'd2023, 4'd6,  5'd1,  1'b0}},
		// Days past the end of the month are pulled back to its last day.
		'{12'd2023, 4'd2,  5'd31, 16'd0,     1'b1, '{12'd2023, 4'd2,  5'd28, 1'b0}},
		'{12'd2024, 4'd2,  5'd30, 16'd0,     1'b1, '{12'd2024, 4'd2,  5'd29, 1'b0}},
		'{12'd1900, 4'd2,  5'd29, 16'd0,     1'b1, '{12'd1900, 4'd2,  5'd28, 1'b0}},
		'{12'd2000, 4'd2,  5'd31, 16'd0,     1'b1, '{12'd2000, 4'd2,  5'd29, 1'b0}},
		'{12'd2023, 4'd4,  5'd31, 16'd0,     1'b1, '{12'd2023, 4'd4,  5'd30, 1'b0}},
		// Stepping over the end of February in common, leap and century years.
		'{12'd2023, 4'd2,  5'd28, 16'd1,     1'b1, '{12'd2023, 4'd3,  5'd1,  1'b0}},
		'{12'd2024, 4'd2,  5'd28, 16'd1,     1'b1, '{12'd2024, 4'd2,  5'd29, 1'b0}},
		'{12'd2100, 4'd2,  5'd28, 16'd1,     1'b1, '{12'd2100, 4'd3,  5'd1,  1'b0}},
		'{12'd2023, 4'd12, 5'd31, 16'd1,     1'b1, '{12'd2024, 4'd1,  5'd1,  1'b0}},
		'{12'd2400, 4'd12, 5'd31, 16'd60,    1'b1, '{12'd2401, 4'd3,  5'd1,  1'b0}},
		'{12'd1,    4'd1,  5'd31, 16'd31,    1'b1, '{12'd1,    4'd3,  5'd3,  1'b0}},
		// Landing exactly on the last representable day is not an overflow.
		'{12'd4094, 4'd12, 5'd31, 16'd365,   1'b1, '{12'd4095, 4'd12, 5'd31, 1'b0}},
		'{12'd4095, 4'd1,  5'd1,  16'd0,     1'b1, '{12'd4095, 4'd1,  5'd1,  1'b0}},
		// One day past it saturates and flags the overflow.
		'{12'd4094, 4'd12, 5'd31, 16'd366,   1'b1, '{12'd4095, 4'd12, 5'd31, 1'b1}},
		'{12'd4095, 4'd12, 5'd31, 16'd1,     1'b1, '{12'd4095, 4'd12, 5'd31, 1'b1}},
		'{12'd4095, 4'd15, 5'd31, 16'd65535, 1'b1, '{12'd4095, 4'd12, 5'd31, 1'b1}},
		// Largest counts from the bottom and the middle of the year range, and a mid-size count high up.
		'{12'd1,    4'd1,  5'd1,  16'd65535, 1'b0, '0},
		'{12'd2000, 4'd1,  5'd1,  16'd65535, 1'b0, '0},
		'{12'd3000, 4'd7,  5'd4,  16'd12345, 1'b0, '0}
	};

	gregorian_date_add_days_top #(
		.YEAR_WIDTH(YW),
		.COUNT_WIDTH(CW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.start_year(start_year),
		.start_month(start_month),
		.start_day(start_day),
		.days_to_add(days_to_add),
		.done(done),
		.result_year(result_year),
		.result_month(result_month),
		.result_day(result_day),
		.year_overflow(year_overflow)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Gregorian rule: every fourth year, except centuries not divisible by 400.
	function automatic bit leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
		case (m)
			MONTH_FEB: return leap_year(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	// Date reached by adding n days, after the incoming date has been clamped
	// into range. Whole years are consumed first, then whole months.
	function automatic date_t advance_date(input logic [YW-1:0] y_in, input logic [3:0] m_in,
			input logic [4:0] d_in, input logic [CW-1:0] n);
		int unsigned y;
		int unsigned m;
		int unsigned d;
		int unsigned rem;
		int unsigned ylen;
		bit ovf;
		date_t r;
		y = y_in;
		m = m_in;
		d = d_in;
		ovf = 1'b0;
		if (y == 0)
			y = 1;
		if (m == 0)
			m = 1;
		if (m > 12)
			m = 12;
		if (d == 0)
			d = 1;
		if (d > month_length(y, m))
			d = month_length(y, m);

		// Day of the year, one-based, plus the count.
		rem = d + n;
		for (int unsigned i = 1; i < m; i++)
			rem += month_length(y, i);

		ylen = leap_year(y) ? 366 : 365;
		while (!ovf && rem > ylen) begin
			rem -= ylen;
			if (y >= LAST_YEAR)
				ovf = 1'b1;
			else
				y++;
			ylen = leap_year(y) ? 366 : 365;
		end

		if (ovf) begin
			r.year = YW'(LAST_YEAR);
			r.month = MONTH_DEC;
			r.day = DAY_LAST_DEC;
		end else begin
			m = 1;
			while (m < 12 && rem > month_length(y, m)) begin
				rem -= month_length(y, m);
				m++;
			end
			r.year = YW'(y);
			r.month = 4'(m);
			r.day = 5'(rem);
		end
		r.ovf = ovf;
		return r;
	endfunction

	// Mostly back to back or short pauses, now and then a long one. Every third
	// block of 40 requests runs with no pauses at all.
	function automatic int unsigned pick_gap(input int unsigned idx);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if ((idx / 40) % 3 == 2)
			return 0;
		if (roll < 45)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 8);
		return $urandom_range(20, 120);
	endfunction

	// Presents one request and holds it until the block takes it: a request is
	// taken at an edge where start is high and busy is low. The edge is sampled
	// before the block's own registers update, so the busy we read is the value
	// that decided acceptance. On return start is left high when gap is zero so
	// that back-to-back requests never lower and raise it in the same step.
	task automatic send_request(input logic [YW-1:0] y, input logic [3:0] m,
			input logic [4:0] d, input logic [CW-1:0] n, input date_t want,
			input int unsigned gap);
		start <= 1'b1;
		start_year <= y;
		start_month <= m;
		start_day <= d;
		days_to_add <= n;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_dates.push_back(want);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Results are single-cycle strobes; each one is matched against the oldest
	// date still owed, field by field.
	always @(posedge clk) begin : result_check
		date_t want;
		if (arst_n && done) begin
			if (pending_dates.size() == 0) begin
				$display("%0t: result with no request outstanding: %0d-%0d-%0d ovf %0b",
					$time, result_year, result_month, result_day, year_overflow);
				mismatch_count++;
			end else begin
				want = pending_dates.pop_front();
				if (result_year !== want.year) begin
					$display("%0t: result_year expected %0d got %0d",
						$time, want.year, result_year);
					mismatch_count++;
				end
				if (result_month !== want.month) begin
					$display("%0t: result_month expected %0d got %0d",
						$time, want.month, result_month);
					mismatch_count++;
				end
				if (result_day !== want.day) begin
					$display("%0t: result_day expected %0d got %0d",
						$time, want.day, result_day);
					mismatch_count++;
				end
				if (year_overflow !== want.ovf) begin
					$display("%0t: year_overflow expected %0b got %0b",
						$time, want.ovf, year_overflow);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t: timed out with %0d results outstanding",
				$time, pending_dates.size());
			$display("gregorian_date_add_days_top test failed");
			$finish;
		end
	end

	initial begin : stimulus
		logic [YW-1:0] y;
		logic [3:0]    m;
		logic [4:0]    d;
		logic [CW-1:0] n;
		int unsigned   kind;
		int unsigned   span;
		date_t         want;

		mismatch_count = 0;
		cycle_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		start_year = '0;
		start_month = '0;
		start_day = '0;
		days_to_add = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed table first.
		for (int unsigned i = 0; i < DIRECTED_REQUESTS; i++) begin
			if (directed_rows[i].typed)
				want = directed_rows[i].want;
			else
				want = advance_date(directed_rows[i].year, directed_rows[i].month,
					directed_rows[i].day, directed_rows[i].count);
			send_request(directed_rows[i].year, directed_rows[i].month, directed_rows[i].day,
				directed_rows[i].count, want, pick_gap(i));
		end

		// Random requests. Most carry a well-formed date; some sit near the top of
		// the year range with large counts to reach the saturation; the rest are
		// raw bit patterns that exercise every clamp.
		for (int unsigned i = 0; i < RANDOM_REQUESTS; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 75) begin
				if (kind < 60)
					y = YW'($urandom_range(1, LAST_YEAR));
				else
					y = YW'($urandom_range(LAST_YEAR - 195, LAST_YEAR));
				m = 4'($urandom_range(1, 12));
				d = 5'($urandom_range(1, month_length(y, m)));
			end else begin
				y = YW'($urandom);
				m = 4'($urandom);
				d = 5'($urandom);
			end

			span = $urandom_range(0, 99);
			if (kind >= 60 && kind < 75)
				n = CW'($urandom_range(30000, 65535));
			else if (span < 45)
				n = CW'($urandom_range(0, 400));
			else if (span < 55)
				n = CW'($urandom_range(360, 370));
			else if (span < 80)
				n = CW'($urandom);
			else
				n = CW'($urandom_range(0, 40));

			send_request(y, m, d, n, advance_date(y, m, d, n),
				pick_gap(i + DIRECTED_REQUESTS));
		end

		// The last request leaves start high only if it had no pause after it.
		if (start)
			start <= 1'b0;

		while (pending_dates.size() != 0)
			@(posedge clk);
		// Any stray strobe would show up within one worst-case request time.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("gregorian_date_add_days_top test passed");
		else
			$display("gregorian_date_add_days_top test failed");
		$finish;
	end

endmodule

[gregorian_date_add_days_top.f]
hw/rtl/gda_pkg.sv
hw/rtl/gda_ctrl.sv
hw/rtl/gda_dp.sv
hw/rtl/gregorian_date_add_days_top.sv
bench/gregorian_date_add_days_top_tb.sv
